// ===== src/fbde_pkg.sv =====
package fbde_pkg;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;

  // Reset values of the configuration registers.
  localparam logic [15:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [15:0] LONG_PRESS_RESET = 16'd3000;

  // Event codes.
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_PREV  = 3'd1;
  localparam logic [2:0] EV_START = 3'd2;
  localparam logic [2:0] EV_NEXT  = 3'd3;
  localparam logic [2:0] EV_MODE  = 3'd4;

  // One scan: raw active-low levels and a timestamp.
  typedef struct packed {
    logic [3:0]  button_levels;
    logic [31:0] now_ms;
  } in_item_t;

  // One result of a scan.
  typedef struct packed {
    logic [2:0]  button_event;
    logic        beep;
    logic [3:0]  pressed_mask;
    logic [31:0] hold_duration_ms;
  } out_item_t;

endpackage

// ===== src/four_button_debounce_events.sv =====
// Debouncer for four active-low buttons with short-press detection on the
// mode button (button 3).
// Input channel (in_valid/in_ready/in_data): one scan per item, carrying the
// raw button levels and a millisecond timestamp. Output channel
// (out_valid/out_ready/out_data): exactly one result item per scan, in order.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is
// the debounce time, index 1 the long-press limit; other indexes are ignored.
// cfg_ready is always high; write only while no scan is in flight.
// An accepted scan is held in the input register while the debounce logic
// and state update feed the result register from it. Throughput is one
// scan per cycle while the receiver does not stall, limited by the single
// time-difference subtract and compare per button between the two registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more scan; in_ready drops only when both are full.
// Reset (synchronous, active high) empties both registers, marks all buttons
// released with a change time of zero, clears the mode hold timer and
// restores the configuration registers to 50 ms and 3000 ms.
module four_button_debounce_events #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fbde_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fbde_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fbde_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import fbde_pkg::*;

  // Configuration registers.
  logic [15:0] debounce_ms;
  logic [15:0] long_press_ms;

  // Input register.
  logic     s_valid;
  in_item_t s_data;

  // Debounce state.
  logic [3:0]           stable_level;
  logic [TIME_BITS-1:0] change_time [4];
  logic [3:0]           pressed_flags;
  logic                 mode_held;
  logic [TIME_BITS-1:0] hold_start;

  // Scan logic signals.
  logic                 advance;
  logic [TIME_BITS+31:0] now_wide;
  logic [TIME_BITS-1:0] now_t;
  logic [3:0]           take;
  logic [3:0]           lvl;
  logic [TIME_BITS-1:0] held_diff;
  logic [TIME_BITS+31:0] held_wide;
  logic                 short_press;
  logic                 mode_release;
  out_item_t            result_next;
  logic [3:0]           pressed_next;

  assign cfg_ready = 1'b1;

  // The scan in the input register moves on when the result register is free.
  assign advance  = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || advance;

  // Timestamp brought to the internal time width.
  assign now_wide  = {{TIME_BITS{1'b0}}, s_data.now_ms};
  assign now_t     = now_wide[TIME_BITS-1:0];
  assign lvl       = s_data.button_levels;
  assign held_diff = now_t - hold_start;
  assign held_wide = {32'd0, held_diff};

  // Per-button acceptance of a level change.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      take[i] = (lvl[i] != stable_level[i]) &&
                ((now_t - change_time[i]) > TIME_BITS'(debounce_ms));
    end
  end

  assign mode_release = take[3] && lvl[3];
  assign short_press  = held_diff < TIME_BITS'(long_press_ms);

  // Result of the scan; the highest button number wins the event.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pressed_next[i] = take[i] ? !lvl[i] : pressed_flags[i];
    end
    result_next.button_event = EV_NONE;
    if (take[0] && !lvl[0]) begin
      result_next.button_event = EV_PREV;
    end
    if (take[1] && !lvl[1]) begin
      result_next.button_event = EV_START;
    end
    if (take[2] && !lvl[2]) begin
      result_next.button_event = EV_NEXT;
    end
    if (mode_release && short_press) begin
      result_next.button_event = EV_MODE;
    end
    result_next.beep         = |(take & ~lvl);
    result_next.pressed_mask = pressed_next;
    if (mode_held && !take[3]) begin
      result_next.hold_duration_ms = held_wide[31:0];
    end else begin
      result_next.hold_duration_ms = 32'd0;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DEBOUNCE_RESET;
      long_press_ms <= LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE:   debounce_ms   <= cfg_data;
        REG_LONG_PRESS: long_press_ms <= cfg_data;
        default:        ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_data <= in_data;
    end
  end

  // Debounce state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level  <= 4'hF;
      pressed_flags <= 4'h0;
      mode_held     <= 1'b0;
      hold_start    <= '0;
      for (int i = 0; i < 4; i++) begin
        change_time[i] <= '0;
      end
    end else if (advance) begin
      pressed_flags <= pressed_next;
      for (int i = 0; i < 4; i++) begin
        if (take[i]) begin
          stable_level[i] <= lvl[i];
          change_time[i]  <= now_t;
        end
      end
      if (take[3]) begin
        mode_held  <= !lvl[3];
        hold_start <= lvl[3] ? '0 : now_t;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_next;
    end
  end

`ifndef SYNTHESIS
  // A beep means a press was accepted, so some button shows as pressed.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.beep |-> out_data.pressed_mask != 4'h0)
    else $error("beep without any pressed button");

  // A hold time is only reported while the mode button is pressed.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.pressed_mask[3] |-> out_data.hold_duration_ms == 32'd0)
    else $error("hold time reported with mode button released");

  // A mode event comes from a release, so the mode button is no longer pressed.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.button_event == EV_MODE |-> !out_data.pressed_mask[3])
    else $error("mode event while mode button pressed");

  // Press events always come with a beep.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.button_event == EV_PREV || out_data.button_event == EV_START ||
                  out_data.button_event == EV_NEXT) |-> out_data.beep)
    else $error("press event without beep");

  // The hold flag tracks the mode button's pressed flag.
  assert property (@(posedge clk) disable iff (rst)
    mode_held == pressed_flags[3])
    else $error("mode hold flag out of step with pressed flag");
`endif

endmodule
